// ===== rtl/ckl_pkg.sv =====
// Package for the compacting key list: sizes, operation codes and result codes.
// Used by the top level compacting_key_list_unit; depends on nothing else.
package ckl_pkg;

  // Capacity of the list and the number of significant key bytes.
  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned KEY_BYTES   = 16;

  // Derived widths.
  localparam int unsigned KEY_W       = 8 * KEY_BYTES;
  localparam int unsigned IDX_W       = $clog2(ENTRIES);
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned COUNT_OUT_W = 5;

  // Operation codes on the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result codes on the status field.
  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_LIST_FULL = 2'd1,
    STAT_REMOVED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ===== rtl/ckl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; has no package dependency.
module ckl_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; the array holds payload only and has no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/compacting_key_list_unit.sv =====
// Top level of the compacting key list: sequencer, count and result register.
// Depends on ckl_pkg and on the slot memory ckl_ram.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | action_i, key_low_i, key_high_i
//   out     | output    | out_valid_o/out_ready_i | status_o, entry_count_o
//
// An insert, an empty-key remove or a remove on an empty list goes straight to ST_FINISH,
// which raises out_valid_o once the output register is free or being emptied. Any other
// remove reads the filled slots in turn for the key, then moves each later slot down one;
// a miss stops at the last filled slot. The single read port makes both steps serial.
// Reset clears the count and the sequencer at once; slots at or above the count are
// never read, so the memory needs no clearing. A result waiting on out_ready_i does
// not stop the next word from being accepted; the sequencer holds only at its end.
module compacting_key_list_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] key_low_i,
  input  logic [63:0] key_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned KeyW  = ckl_pkg::KEY_W;
  localparam int unsigned IdxW  = ckl_pkg::IDX_W;
  localparam int unsigned CntW  = ckl_pkg::CNT_W;
  localparam int unsigned KeyB  = ckl_pkg::KEY_BYTES;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_SEARCH_RD  = 6'b000010,
    ST_SEARCH_CMP = 6'b000100,
    ST_SHIFT_RD   = 6'b001000,
    ST_SHIFT_WR   = 6'b010000,
    ST_FINISH     = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   idx_inc;
  logic [KeyW-1:0]   key_q, key_d;
  ckl_pkg::status_e  status_q, status_d;
  logic              out_valid_q, out_valid_d;
  ckl_pkg::status_e  out_status_q;
  logic [ckl_pkg::COUNT_OUT_W-1:0] out_count_q;
  logic              out_load;
  logic              list_full;

  logic [127:0]      raw_key;
  logic [KeyB-1:0]   byte_alive;
  logic [KeyB-1:0]   byte_keep;
  logic [KeyW-1:0]   key_norm;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [KeyW-1:0]   mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic [KeyW-1:0]   mem_rdata;

  // Key normalization: a byte survives only if it and every byte below it are nonzero.
  assign raw_key = {key_high_i, key_low_i};

  always_comb begin
    logic [KeyB-1:0] low_mask;
    low_mask = '0;
    for (int b = 0; b < KeyB; b++) begin
      byte_alive[b] = |raw_key[8*b +: 8];
    end
    for (int b = 0; b < KeyB; b++) begin
      low_mask     = KeyB'((33'd1 << (b + 1)) - 33'd1);
      byte_keep[b] = ((byte_alive & low_mask) == low_mask);
      key_norm[8*b +: 8] = byte_keep[b] ? raw_key[8*b +: 8] : 8'h00;
    end
  end

  assign list_full  = (count_q == CntW'(ckl_pkg::ENTRIES));
  assign idx_inc    = idx_q + CntW'(1);
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: decide on accept, then search and shift through the slot memory.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[IdxW-1:0];
    mem_wdata = key_norm;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d   = key_norm;
          idx_d   = '0;
          state_d = ST_FINISH;
          if (action_i == ckl_pkg::ACT_INSERT) begin
            if (list_full) begin
              status_d = ckl_pkg::STAT_LIST_FULL;
            end else begin
              status_d = ckl_pkg::STAT_INSERTED;
              if (key_norm != '0) begin
                mem_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
          end else if (key_norm == '0) begin
            status_d = list_full ? ckl_pkg::STAT_NOT_FOUND : ckl_pkg::STAT_REMOVED;
          end else if (count_q == '0) begin
            status_d = ckl_pkg::STAT_NOT_FOUND;
          end else begin
            state_d = ST_SEARCH_RD;
          end
        end
      end
      ST_SEARCH_RD: begin
        mem_re  = 1'b1;
        state_d = ST_SEARCH_CMP;
      end
      ST_SEARCH_CMP: begin
        if (mem_rdata == key_q) begin
          state_d = ST_SHIFT_RD;
        end else if (idx_inc == count_q) begin
          status_d = ckl_pkg::STAT_NOT_FOUND;
          state_d  = ST_FINISH;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_SEARCH_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (idx_inc < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IdxW-1:0];
          state_d   = ST_SHIFT_WR;
        end else begin
          count_d  = count_q - CntW'(1);
          status_d = ckl_pkg::STAT_REMOVED;
          state_d  = ST_FINISH;
        end
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[IdxW-1:0];
        mem_wdata = mem_rdata;
        idx_d     = idx_inc;
        state_d   = ST_SHIFT_RD;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the word is taken.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_count_q  <= ckl_pkg::COUNT_OUT_W'(count_q);
    end
  end

  // Slot memory.
  ckl_ram #(
    .WIDTH (KeyW),
    .DEPTH (ckl_pkg::ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

`ifndef ASSERT_OFF
  // The count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ckl_pkg::ENTRIES))
    else $error("filled count above capacity");

  // While searching or shifting, the slot index stays inside the filled region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH_RD || state_q == ST_SEARCH_CMP ||
     state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) |-> (idx_q < count_q))
    else $error("slot index outside filled region");

  // The count moves by at most one per operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CntW'(1) || count_q == $past(count_q) - CntW'(1)))
    else $error("filled count jumped");

  // A result is loaded only when the output register is free or being emptied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a waiting word");
`endif

endmodule
